// ----- rtl/rtpjb_pkg.sv -----
`timescale 1ns / 1ps
package rtpjb_pkg;

  localparam int SEQ_W    = 16;
  localparam int FRAMES_W = 16;
  localparam int TAG_W    = 16;
  localparam int BUF_MS_W = 16;

  localparam int MS_PER_PACKET    = 20;
  localparam int LOOKAHEAD        = 4;
  localparam int MAX_RESULTS      = 64;
  localparam int PREFILL_MS_RESET = 50;

  // Packet count needed before playout: the prefill target / 20 fits in 12 bits.
  localparam int NEED_W = 12;
  localparam int NEED_DIV = PREFILL_MS_RESET / MS_PER_PACKET;
  localparam logic [NEED_W-1:0] NEED_RESET = NEED_W'((NEED_DIV < 1) ? 1 : NEED_DIV);

  // x / 20 == (x >> 2) / 5, and y / 5 == (y * 0xCCCD) >> 18 for 16-bit y.
  localparam int DIV5_MUL   = 16'hCCCD;
  localparam int DIV5_SHIFT = 18;
  localparam int DIV5_MUL_W = 16;

  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int LOOK_W      = $clog2(LOOKAHEAD + 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_STORE,
    ST_RD,
    ST_EV,
    ST_LRD,
    ST_LEV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic mod_step;
    logic store;
    logic walk_init;
    logic rd_ptr;
    logic emit;
    logic skip;
    logic look_start;
    logic look_rd;
    logic look_next;
    logic flush_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic drop;
    logic mod_done;
    logic walk_go;
    logic filled;
    logic more_emit;
    logic more_skip;
    logic look_last;
    logic push_ok;
    logic pend_valid;
  } dp_stat_t;

endpackage

// ----- rtl/rtpjb_in_if.sv -----
`timescale 1ns / 1ps
interface rtpjb_in_if import rtpjb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    seq_num;
  logic [FRAMES_W-1:0] frames;
  logic [TAG_W-1:0]    payload_tag;

  modport source (output valid, seq_num, frames, payload_tag, input ready);
  modport sink   (input valid, seq_num, frames, payload_tag, output ready);
endinterface

// ----- rtl/rtpjb_out_if.sv -----
`timescale 1ns / 1ps
interface rtpjb_out_if import rtpjb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    out_seq;
  logic [FRAMES_W-1:0] out_frames;
  logic [TAG_W-1:0]    out_tag;
  logic                last_of_run;

  modport source (output valid, out_seq, out_frames, out_tag, last_of_run, input ready);
  modport sink   (input valid, out_seq, out_frames, out_tag, last_of_run, output ready);
endinterface

// ----- rtl/rtp_jitter_buffer_playout.sv -----
`timescale 1ns / 1ps
// An item is accepted, its slot index is reduced in two steps (quotient, then remainder),
// and it is written. One item at a time; each visited slot is read and evaluated, a
// lookahead reads further slots past an empty one, and the final result is released
// last; a blocked play output stalls the walk. A dropped item is consumed without a store.
// Reset: synchronous, active high; afterwards a clearing pass writes all RING_SLOTS slots,
// one per cycle, with pkt.ready low. The prefill target returns to 50 ms, pointer to 0.
module rtp_jitter_buffer_playout import rtpjb_pkg::*; #(
  parameter int RING_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  rtpjb_in_if.sink            pkt,
  rtpjb_out_if.source         play,
  input  logic                cfg_we,
  input  logic [BUF_MS_W-1:0] cfg_data
);

  // The controller sequences: clear pass, accept, slot-index reduction,
  // store, then the playout walk. The datapath holds the slot memory,
  // the playout pointer, the walk counters and the output register.
  // One result is held back as pending so the final result of a walk
  // can carry last_of_run once the walk knows it is done.

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rtpjb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(pkt.valid),
    .in_ready(pkt.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rtpjb_dp #(
    .RING_SLOTS(RING_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_seq    (pkt.seq_num),
    .in_frames (pkt.frames),
    .in_tag    (pkt.payload_tag),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (play.valid),
    .out_ready (play.ready),
    .out_seq   (play.out_seq),
    .out_frames(play.out_frames),
    .out_tag   (play.out_tag),
    .out_last  (play.last_of_run)
  );

endmodule

// ----- rtl/rtpjb_ram.sv -----
`timescale 1ns / 1ps
module rtpjb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rtpjb_ctrl.sv -----
`timescale 1ns / 1ps
module rtpjb_ctrl import rtpjb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !stat.drop) begin
          cmd.take   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.walk_go) begin
          cmd.walk_init = 1'b1;
          state_next    = ST_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd_ptr = 1'b1;
        state_next = ST_EV;
      end
      ST_EV: begin
        if (stat.filled) begin
          // hold while the previous result cannot move to the output
          if (!stat.pend_valid || stat.push_ok) begin
            cmd.emit   = 1'b1;
            state_next = stat.more_emit ? ST_RD : ST_FIN;
          end
        end else begin
          cmd.look_start = 1'b1;
          state_next     = ST_LRD;
        end
      end
      ST_LRD: begin
        cmd.look_rd = 1'b1;
        state_next  = ST_LEV;
      end
      ST_LEV: begin
        priority if (stat.filled) begin
          cmd.skip   = 1'b1;
          state_next = stat.more_skip ? ST_RD : ST_FIN;
        end else if (stat.look_last) begin
          state_next = ST_FIN;
        end else begin
          cmd.look_next = 1'b1;
          state_next    = ST_LRD;
        end
      end
      ST_FIN: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.push_ok) begin
          cmd.flush_last = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/rtpjb_dp.sv -----
`timescale 1ns / 1ps
module rtpjb_dp import rtpjb_pkg::*; #(
  parameter int RING_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [BUF_MS_W-1:0] cfg_data,
  input  logic [SEQ_W-1:0]    in_seq,
  input  logic [FRAMES_W-1:0] in_frames,
  input  logic [TAG_W-1:0]    in_tag,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SEQ_W-1:0]    out_seq,
  output logic [FRAMES_W-1:0] out_frames,
  output logic [TAG_W-1:0]    out_tag,
  output logic                out_last
);

  localparam int SLOT_W  = $clog2(RING_SLOTS);
  localparam int VISIT_W = $clog2(RING_SLOTS + 1);
  localparam int ENTRY_W = FRAMES_W + TAG_W;
  localparam int CFG_Q_W = BUF_MS_W - 2;
  localparam int PROD_W  = CFG_Q_W + DIV5_MUL_W;

  // seq / RING_SLOTS == (seq * RECIP_M) >> RECIP_S for every 16-bit seq
  localparam int RECIP_S = SEQ_W + SLOT_W;
  localparam int RECIP_M = ((1 << RECIP_S) + RING_SLOTS - 1) / RING_SLOTS;
  localparam int RECIP_W = SEQ_W + 1;
  localparam int MPROD_W = SEQ_W + RECIP_W;
  localparam int QUO_W   = MPROD_W - RECIP_S;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(RING_SLOTS - 1);
  localparam logic [VISIT_W:0]   VISIT_LIM = (VISIT_W + 1)'(RING_SLOTS);
  localparam logic [RES_CNT_W:0] RES_LIM   = (RES_CNT_W + 1)'(MAX_RESULTS);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SEQ_W-1:0]  p,
                                                 input logic [SLOT_W-1:0] s);
    // 16-bit sequence wrap restarts the slot at zero as well
    if (p == {SEQ_W{1'b1}} || s == SLOT_LAST) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // configuration: packets needed before playout
  logic [NEED_W-1:0]  need;
  logic [CFG_Q_W-1:0] cfg_q4;
  logic [PROD_W-1:0]  cfg_prod;
  logic [NEED_W-1:0]  need_cfg;

  assign cfg_q4   = cfg_data[BUF_MS_W-1:2];
  assign cfg_prod = PROD_W'(cfg_q4) * PROD_W'(DIV5_MUL);
  assign need_cfg = cfg_prod[DIV5_SHIFT +: NEED_W];

  // state
  logic               prefilling;
  logic [SEQ_W-1:0]   ptr;
  logic [SLOT_W-1:0]  ptr_slot;
  logic               ld_ptr;
  logic [SEQ_W-1:0]   seq_q;
  logic [FRAMES_W-1:0] frames_q;
  logic [TAG_W-1:0]   tag_q;
  logic [SLOT_W-1:0]  mod_rem;
  logic               mod_phase;
  logic [QUO_W-1:0]   quot;
  logic [LOOK_W-1:0]  look_k;
  logic [SEQ_W-1:0]   look_ptr;
  logic [SLOT_W-1:0]  look_slot;
  logic [VISIT_W-1:0] visits;
  logic [RES_CNT_W-1:0] res_cnt;
  logic               pend_valid;
  logic [SEQ_W-1:0]   pend_seq;
  logic [FRAMES_W-1:0] pend_frames;
  logic [TAG_W-1:0]   pend_tag;
  logic [SLOT_W-1:0]  clr_addr;

  // accept-time prefill decision
  logic             load;
  logic [SEQ_W-1:0] seq_lead;
  logic             prefill_end;

  assign load        = prefilling && (ptr == '0) && (in_seq != '0);
  assign seq_lead    = in_seq - (load ? in_seq : ptr);
  assign prefill_end = !seq_lead[SEQ_W-1] && (seq_lead >= SEQ_W'(need));

  // slot index in two steps: reciprocal quotient, then remainder
  logic [MPROD_W-1:0] mod_prod;
  logic [SEQ_W-1:0]   quot_back;
  logic [SEQ_W-1:0]   mod_diff;

  assign mod_prod  = MPROD_W'(seq_q) * MPROD_W'(RECIP_M);
  assign quot_back = SEQ_W'(quot) * SEQ_W'(RING_SLOTS);
  assign mod_diff  = seq_q - quot_back;

  // slot memory: frames above tag
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [FRAMES_W-1:0] rd_frames;
  logic [TAG_W-1:0]   rd_tag;

  always_comb begin
    ram_we    = cmd.clr_step || cmd.store || cmd.emit;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (cmd.store) begin
      ram_waddr = mod_rem;
      ram_wdata = {frames_q, tag_q};
    end else if (cmd.emit) begin
      ram_waddr = ptr_slot;
    end
    ram_re    = cmd.rd_ptr || cmd.look_rd;
    ram_raddr = cmd.look_rd ? look_slot : ptr_slot;
  end

  rtpjb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_frames = ram_rdata[TAG_W +: FRAMES_W];
  assign rd_tag    = ram_rdata[TAG_W-1:0];

  logic push;
  assign push = (cmd.emit && pend_valid) || cmd.flush_last;

  always_comb begin
    stat.clr_done   = (clr_addr == SLOT_LAST);
    stat.drop       = (in_frames == '0);
    stat.mod_done   = mod_phase;
    stat.walk_go    = !prefilling;
    stat.filled     = (rd_frames != '0);
    stat.more_emit  = (({1'b0, visits} + 1'b1) < VISIT_LIM)
                   && (({1'b0, res_cnt} + 1'b1) < RES_LIM);
    stat.more_skip  = (({1'b0, visits} + 1'b1) < VISIT_LIM);
    stat.look_last  = (look_k == LOOK_W'(LOOKAHEAD));
    stat.push_ok    = !out_valid || out_ready;
    stat.pend_valid = pend_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need       <= NEED_RESET;
      prefilling <= 1'b1;
      ptr        <= '0;
      ptr_slot   <= '0;
      ld_ptr     <= 1'b0;
      mod_phase  <= 1'b0;
      look_k     <= '0;
      visits     <= '0;
      res_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      clr_addr   <= '0;
    end else begin
      if (cfg_we) begin
        need <= (need_cfg == '0) ? NEED_W'(1) : need_cfg;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.take) begin
        ld_ptr    <= load;
        mod_phase <= 1'b0;
        if (load) begin
          ptr <= in_seq;
        end
        if (prefilling && !load && prefill_end) begin
          prefilling <= 1'b0;
        end
      end
      if (cmd.mod_step) begin
        mod_phase <= !mod_phase;
      end
      if (cmd.store && ld_ptr) begin
        ptr_slot <= mod_rem;
      end
      if (cmd.walk_init) begin
        visits  <= '0;
        res_cnt <= '0;
      end
      if (cmd.emit || cmd.skip) begin
        ptr      <= ptr + 1'b1;
        ptr_slot <= slot_inc(ptr, ptr_slot);
        visits   <= visits + 1'b1;
      end
      if (cmd.emit) begin
        res_cnt    <= res_cnt + 1'b1;
        pend_valid <= 1'b1;
      end else if (cmd.flush_last) begin
        pend_valid <= 1'b0;
      end
      if (cmd.look_start) begin
        look_k <= LOOK_W'(1);
      end else if (cmd.look_next) begin
        look_k <= look_k + 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      seq_q    <= in_seq;
      frames_q <= in_frames;
      tag_q    <= in_tag;
    end else if (cmd.mod_step) begin
      if (!mod_phase) begin
        quot <= mod_prod[RECIP_S +: QUO_W];
      end else begin
        mod_rem <= mod_diff[SLOT_W-1:0];
      end
    end
    if (cmd.look_start) begin
      look_ptr  <= ptr + 1'b1;
      look_slot <= slot_inc(ptr, ptr_slot);
    end else if (cmd.look_next) begin
      look_ptr  <= look_ptr + 1'b1;
      look_slot <= slot_inc(look_ptr, look_slot);
    end
    if (cmd.emit) begin
      pend_seq    <= ptr;
      pend_frames <= rd_frames;
      pend_tag    <= rd_tag;
    end
    if (push) begin
      out_seq    <= pend_seq;
      out_frames <= pend_frames;
      out_tag    <= pend_tag;
      out_last   <= cmd.flush_last;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("result pushed over an unaccepted output item");

  a_emit_filled: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.filled)
    else $error("emit from an empty slot");

  a_prefill_sticky: assert property (@(posedge clk) disable iff (rst)
    !$rose(prefilling))
    else $error("prefilling restarted without reset");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    (res_cnt <= RES_CNT_W'(MAX_RESULTS)) && (look_k <= LOOK_W'(LOOKAHEAD)))
    else $error("walk counter out of range");

endmodule

// ----- verif/tb_rtp_jitter_buffer_playout.sv -----
`timescale 1ns / 1ps
module tb_rtp_jitter_buffer_playout;
  import rtpjb_pkg::*;

  localparam int RING         = 64;
  localparam int DRAIN_CYCLES = 800;      // worst walk: 64 visits, each with a lookahead
  localparam int HOLD_CYCLES  = 600;      // long receiver hold-off, fills the block
  localparam int LIMIT        = 1000000;

  // One emitted packet as it should leave the play channel.
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [FRAMES_W-1:0] frames;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } play_t;

  // Tracks the jitter buffer: prefill state, playout pointer and ring contents,
  // and holds the plays that accepted packets have released but not yet seen.
  class playout_scoreboard;
    logic [BUF_MS_W-1:0] prefill_ms;
    bit                  prefilling;
    logic [SEQ_W-1:0]    ptr;
    logic [FRAMES_W-1:0] frames_at[RING];
    logic [TAG_W-1:0]    tag_at[RING];
    play_t               due_plays[$];
    int                  errors;

    function new();
      prefill_ms = BUF_MS_W'(PREFILL_MS_RESET);
      prefilling = 1'b1;
      ptr        = '0;
      errors     = 0;
      foreach (frames_at[i]) begin
        frames_at[i] = '0;
        tag_at[i]    = '0;
      end
    endfunction

    function void set_prefill_ms(logic [BUF_MS_W-1:0] v);
      prefill_ms = v;
    endfunction

    // Any of the next few slots past the pointer filled?
    function bit ahead_filled();
      logic [SEQ_W-1:0] s;
      for (int k = 1; k <= LOOKAHEAD; k++) begin
        s = ptr + SEQ_W'(k);
        if (frames_at[s % RING] != '0) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Store one accepted packet and queue the plays its walk releases.
    function void note_packet(logic [SEQ_W-1:0] s, logic [FRAMES_W-1:0] f,
                              logic [TAG_W-1:0] t);
      int unsigned      need;
      int unsigned      idx;
      int               n;
      logic [SEQ_W-1:0] lead;
      play_t            held;
      if (f == '0) return;
      if (prefilling && ptr == '0 && s != '0) ptr = s;
      frames_at[s % RING] = f;
      tag_at[s % RING]    = t;
      if (prefilling) begin
        need = prefill_ms / MS_PER_PACKET;
        if (need < 1) need = 1;
        lead = s - ptr;
        if (!lead[SEQ_W-1] && lead >= need) prefilling = 1'b0;
      end
      if (prefilling) return;
      n = 0;
      for (int visits = 0; visits < RING && n < MAX_RESULTS; visits++) begin
        idx = ptr % RING;
        if (frames_at[idx] != '0) begin
          // hold the newest play back so the last one can be marked
          if (n > 0) due_plays = {due_plays, held};
          held = '{seq: ptr, frames: frames_at[idx], tag: tag_at[idx], last: 1'b0};
          n++;
          frames_at[idx] = '0;
          ptr++;
        end else if (ahead_filled()) begin
          ptr++;
        end else begin
          break;
        end
      end
      if (n > 0) begin
        held.last = 1'b1;
        due_plays = {due_plays, held};
      end
    endfunction

    function void flag(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // Compare one accepted play with the oldest one due.
    function void check_play(logic [SEQ_W-1:0] s, logic [FRAMES_W-1:0] f,
                             logic [TAG_W-1:0] t, logic l);
      play_t want;
      if (due_plays.size() == 0) begin
        errors++;
        $display("%0t: unexpected play, expected none, actual seq %h frames %h tag %h",
                 $time, s, f, t);
        return;
      end
      want = due_plays.pop_front();
      if (s !== want.seq)    flag("out_seq", want.seq, s);
      if (f !== want.frames) flag("out_frames", want.frames, f);
      if (t !== want.tag)    flag("out_tag", want.tag, t);
      if (l !== want.last)   flag("last_of_run", want.last, l);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [BUF_MS_W-1:0] cfg_data = '0;

  rtpjb_in_if  pkt();
  rtpjb_out_if play();

  rtp_jitter_buffer_playout #(.RING_SLOTS(RING)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt),
    .play     (play),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  playout_scoreboard sb = new();

  int               src_idle_pct = 27;
  int               snk_idle_pct = 47;
  bit               hold_req = 1'b0;
  int               stored_cnt = 0;    // accepted packets that carry frames
  logic [SEQ_W-1:0] front;             // next in-order sequence number to send
  int               cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run a cycle counter; end the run if it exceeds the limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** rtp_jitter_buffer_playout: FAILED **");
      $finish;
    end
  end

  // Receiver: stall at random; on request, hold off for a long stretch.
  initial begin
    play.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        play.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      play.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Check every play item at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && play.valid && play.ready)
      sb.check_play(play.out_seq, play.out_frames, play.out_tag, play.last_of_run);
  end

  // Offer one packet, idling first at random; return at the accepting edge.
  task automatic offer_packet(input logic [SEQ_W-1:0] s, input logic [FRAMES_W-1:0] f,
                              input logic [TAG_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pkt.valid <= 1'b0;
      @(negedge clk);
    end
    pkt.valid       <= 1'b1;
    pkt.seq_num     <= s;
    pkt.frames      <= f;
    pkt.payload_tag <= t;
    do @(posedge clk); while (!pkt.ready);
    sb.note_packet(s, f, t);
    if (f != '0) stored_cnt++;
  endtask

  // Drop valid, wait for every due play, then let a late walk finish.
  task automatic settle();
    @(negedge clk);
    pkt.valid <= 1'b0;
    while (sb.due_plays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_prefill_ms(input logic [BUF_MS_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_prefill_ms(v);
  endtask

  // Mostly nonzero frame counts, with the extremes and drops now and then.
  function automatic logic [FRAMES_W-1:0] pick_frames();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return FRAMES_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // One step of a mostly in-order stream: small gaps, swaps, late copies, noise.
  task automatic random_packet();
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] lag;
    int               pick;
    if (front - sb.ptr >= 16'h8000) front = sb.ptr;
    lag  = front - sb.ptr;
    pick = $urandom_range(0, 99);
    if (lag > 16'd6 && pick < 40) begin
      // walk is stuck on a wide gap; fill a slot it can see
      s = sb.ptr + SEQ_W'($urandom_range(0, LOOKAHEAD));
    end else if (pick < 5) begin
      s = SEQ_W'($urandom);
    end else if (pick < 12) begin
      s = front - SEQ_W'($urandom_range(1, 8));
    end else if (pick < 22) begin
      front += SEQ_W'($urandom_range(1, 6));
      s = front;
      front++;
    end else if (pick < 32) begin
      offer_packet(front + 16'd1, pick_frames(), TAG_W'($urandom));
      s = front;
      front += 16'd2;
    end else begin
      s = front;
      front++;
    end
    offer_packet(s, pick_frames(), TAG_W'($urandom));
  endtask

  initial begin
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] q;
    int               order[RING-1];
    int               j;
    int               tmp;

    pkt.valid       = 1'b0;
    pkt.seq_num     = '0;
    pkt.frames      = '0;
    pkt.payload_tag = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Largest prefill target: 3276 packets of distance.
    write_prefill_ms(16'hFFFF);

    // Prefill: drop, sequence zero first, pointer load near the wrap.
    base = 16'hFFF0;
    offer_packet(16'd0, 16'd0, 16'hFFFF);
    offer_packet(16'd0, 16'd3, 16'h1111);
    offer_packet(base, 16'hFFFF, 16'h0000);
    offer_packet(base, 16'd9, 16'h2222);                // pointer must not reload
    offer_packet(base - 16'd1, 16'd1, 16'hFFFF);        // negative distance
    offer_packet(base + 16'd3275, 16'd7, 16'h5A5A);     // one short of the target

    // Fill the whole ring in random order so that the first walk runs full.
    for (int i = 0; i < RING - 1; i++) order[i] = i + 1;
    for (int i = RING - 2; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < RING - 1; i++) begin
      if ($urandom_range(0, 9) == 0)
        offer_packet(SEQ_W'($urandom), 16'd0, TAG_W'($urandom));
      offer_packet(base + SEQ_W'(order[i]), FRAMES_W'($urandom_range(1, 65535)),
                   TAG_W'($urandom));
    end
    offer_packet(base + 16'd3276, 16'd5, 16'h0001);     // reaches the target

    // Playout: gap past the lookahead, skips, swap, late copy, drop.
    q = sb.ptr;
    offer_packet(q + 16'd6, 16'd2, 16'hA5A5);
    offer_packet(q + 16'd4, 16'd3, 16'h5A5A);
    offer_packet(q + 16'd8, 16'd1, 16'h0000);
    offer_packet(q + 16'd7, 16'hFFFF, 16'hFFFF);
    offer_packet(q, 16'd4, 16'h1234);
    offer_packet(q + 16'd9, 16'd0, 16'h4321);
    offer_packet(q + 16'd9, 16'd6, 16'h4321);
    offer_packet(q + 16'd9, 16'd2, 16'h8765);
    front = sb.ptr;

    settle();
    write_prefill_ms(16'd1279);
    while (stored_cnt < 210) random_packet();

    settle();
    write_prefill_ms(16'd0);
    src_idle_pct = 47;
    snk_idle_pct = 27;
    while (stored_cnt < 340) random_packet();

    settle();
    write_prefill_ms(16'd50);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 1'b1;
    while (stored_cnt < 470) random_packet();

    settle();
    if (sb.errors == 0) begin
      $display("** rtp_jitter_buffer_playout: PASSED **");
    end else begin
      $display("** rtp_jitter_buffer_playout: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rtpjb_pkg.sv
rtl/rtpjb_in_if.sv
rtl/rtpjb_out_if.sv
rtl/rtpjb_ram.sv
rtl/rtpjb_ctrl.sv
rtl/rtpjb_dp.sv
rtl/rtp_jitter_buffer_playout.sv
verif/tb_rtp_jitter_buffer_playout.sv
